@@ hw/rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// shared types and constants for the preemptive priority scheduler
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TIME_BITS  = 16;

    // field widths of one beat
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 4;
    localparam int ARR_W   = 16;
    localparam int PRI_W   = 8;
    localparam int BURST_W = 16;
    localparam int TICK_W  = 16;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // last slot marker for "nothing ran"
    localparam logic [SLOT_BITS:0] NO_SLOT = (SLOT_BITS + 1)'(SLOT_COUNT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } t_state;

    // one entry of the slot memory
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [PRI_W-1:0]   priority_num;
        logic [BURST_W-1:0] remaining;
    } t_slot_ent;

    // one read beat from the slot memory into the scanner
    typedef struct packed {
        logic                 vld;
        logic                 used;
        logic [SLOT_BITS-1:0] idx;
        t_slot_ent            ent;
    } t_scan_beat;

    // running winner and work count of a scan
    typedef struct packed {
        logic                 found;
        logic [SLOT_BITS-1:0] idx;
        t_slot_ent            ent;
        logic [SLOT_BITS:0]   active_cnt;
    } t_best;

endpackage

@@ hw/rtl/pps_slot_mem.sv @@
// ----------------------------------------------------------------------------
// pps_slot_mem
// slot table: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module pps_slot_mem (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [pps_pkg::SLOT_BITS-1:0] i_wr_addr,
    input  pps_pkg::t_slot_ent            i_wr_data,
    input  logic                          i_rd_en,
    input  logic [pps_pkg::SLOT_BITS-1:0] i_rd_addr,
    output pps_pkg::t_slot_ent            o_rd_data
);

    pps_pkg::t_slot_ent r_mem [pps_pkg::SLOT_COUNT];
    pps_pkg::t_slot_ent r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/pps_scan.sv @@
// ----------------------------------------------------------------------------
// pps_scan
// keeps the best ready slot and the count of slots with work over one scan
// ----------------------------------------------------------------------------
module pps_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  pps_pkg::t_scan_beat           i_beat,
    input  logic [pps_pkg::TIME_BITS-1:0] i_now,
    output pps_pkg::t_best                o_best
);

    pps_pkg::t_best r_best;
    pps_pkg::t_best n_best;

    logic has_work;
    logic ready;
    logic better;

    always_comb begin
        has_work = i_beat.used && (i_beat.ent.remaining != '0);
        ready    = has_work && (32'(i_beat.ent.arrival) <= 32'(i_now));
        // lower priority number wins, then earlier arrival; index order keeps ties
        better   = !r_best.found
                || (i_beat.ent.priority_num < r_best.ent.priority_num)
                || ((i_beat.ent.priority_num == r_best.ent.priority_num)
                    && (i_beat.ent.arrival < r_best.ent.arrival));

        n_best = r_best;
        if (i_start) begin
            n_best.found      = 1'b0;
            n_best.active_cnt = '0;
        end else if (i_beat.vld) begin
            if (has_work) begin
                n_best.active_cnt = r_best.active_cnt + 1'b1;
            end
            if (ready && better) begin
                n_best.found = 1'b1;
                n_best.idx   = i_beat.idx;
                n_best.ent   = i_beat.ent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best.found      <= 1'b0;
            r_best.active_cnt <= '0;
        end else begin
            r_best.found      <= n_best.found;
            r_best.active_cnt <= n_best.active_cnt;
        end
        r_best.idx <= n_best.idx;
        r_best.ent <= n_best.ent;
    end

    assign o_best = r_best;

endmodule

@@ hw/rtl/preemptive_priority_scheduler.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// task slot table with a one-tick-at-a-time priority dispatcher
// ----------------------------------------------------------------------------
//
// channel   dir  fields (lowest bit first)
// s_axis    in   tuser: cmd[1:0]
//                tdata: slot[3:0] arrival_time[19:4] task_priority[27:20]
//                       burst_length[43:28], zero pad [47:44]
// m_axis    out  tdata: run_slot[3:0] idle[4] switched[5] first_run[6]
//                       finished[7] tick_time[23:8] all_done[24], zero pad
//
// clear and load beats give no result beat.
// a tick beat reads the table one slot at a time, lets the last read land in
// the drain state, then writes back the winner in the update state.
// the table memory has a single read port, so the scan is what sets the rate.
// reset (synchronous, active low) empties the table and zeroes the time.
// the result sits in an output register, so a new beat is taken while it
// waits; a second tick holds at write-back until that register frees.
//
module preemptive_priority_scheduler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pps_pkg::CMD_W-1:0]       s_axis_tuser,  // cmd
    input  logic [pps_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // slot, arrival_time,
                                                           // task_priority, burst_length

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pps_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // run_slot, idle, switched,
                                                           // first_run, finished,
                                                           // tick_time, all_done
);

    // input field split
    logic [pps_pkg::SLOT_W-1:0]  in_slot;
    logic [pps_pkg::ARR_W-1:0]   in_arrival;
    logic [pps_pkg::PRI_W-1:0]   in_priority;
    logic [pps_pkg::BURST_W-1:0] in_burst;

    assign in_slot     = s_axis_tdata[3:0];
    assign in_arrival  = s_axis_tdata[19:4];
    assign in_priority = s_axis_tdata[27:20];
    assign in_burst    = s_axis_tdata[43:28];

    // control state
    pps_pkg::t_state r_state;
    pps_pkg::t_state n_state;

    logic [pps_pkg::SLOT_COUNT-1:0] r_valid;     // slot loaded since clear
    logic [pps_pkg::SLOT_COUNT-1:0] r_started;   // slot has run at least once
    logic [pps_pkg::TIME_BITS-1:0]  r_now;
    logic [pps_pkg::SLOT_BITS:0]    r_last;      // NO_SLOT when nothing carries over
    logic [pps_pkg::SLOT_BITS-1:0]  r_addr;      // scan read address
    logic                           r_rd_vld;    // read data lands this cycle
    logic [pps_pkg::SLOT_BITS-1:0]  r_rd_idx;

    // output register
    logic                              r_out_vld;
    logic [pps_pkg::OUT_DATA_W-1:0]    r_out_data;

    // fsm outputs
    logic in_beat;
    logic rd_en;
    logic scan_start;
    logic upd_fire;
    logic out_free;
    logic scan_last;

    // memory and scanner hookup
    logic                          wr_en;
    logic [pps_pkg::SLOT_BITS-1:0] wr_addr;
    pps_pkg::t_slot_ent            wr_data;
    pps_pkg::t_slot_ent            rd_data;
    pps_pkg::t_scan_beat           scan_beat;
    pps_pkg::t_best                best;

    logic load_ok;
    logic fin;
    logic done;
    logic sw;
    logic first;
    logic [pps_pkg::BURST_W-1:0] rem_dec;

    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_vld || m_axis_tready;
    assign scan_last = (r_addr == pps_pkg::SLOT_BITS'(pps_pkg::SLOT_COUNT - 1));
    assign load_ok   = (32'(in_slot) < pps_pkg::SLOT_COUNT);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pps_pkg::ST_IDLE: begin
                if (in_beat && (s_axis_tuser == pps_pkg::CMD_TICK)) begin
                    n_state = pps_pkg::ST_SCAN;
                end
            end
            pps_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = pps_pkg::ST_DRAIN;
                end
            end
            pps_pkg::ST_DRAIN: begin
                n_state = pps_pkg::ST_UPDATE;
            end
            pps_pkg::ST_UPDATE: begin
                if (out_free) begin
                    n_state = pps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pps_pkg::ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        scan_start    = 1'b0;
        upd_fire      = 1'b0;
        case (r_state)
            pps_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                scan_start    = in_beat && (s_axis_tuser == pps_pkg::CMD_TICK);
            end
            pps_pkg::ST_SCAN: begin
                rd_en = 1'b1;
            end
            pps_pkg::ST_DRAIN: begin
                rd_en = 1'b0;
            end
            pps_pkg::ST_UPDATE: begin
                upd_fire = out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // winner bookkeeping
    always_comb begin
        rem_dec = best.ent.remaining - 1'b1;
        fin     = best.found && (rem_dec == '0);
        sw      = best.found && ({1'b0, best.idx} != r_last);
        first   = best.found && !r_started[best.idx];
        // the winner was counted in the scan; it drops out if it just finished
        done    = (best.active_cnt == '0)
               || ((best.active_cnt == (pps_pkg::SLOT_BITS + 1)'(1)) && fin);
    end

    // memory write: a load from idle, or write-back of the winner
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = best.idx;
        wr_data = best.ent;
        wr_data.remaining = rem_dec;
        if (r_state == pps_pkg::ST_IDLE) begin
            wr_en   = in_beat && (s_axis_tuser == pps_pkg::CMD_LOAD) && load_ok;
            wr_addr = pps_pkg::SLOT_BITS'(in_slot);
            wr_data.arrival      = in_arrival;
            wr_data.priority_num = in_priority;
            wr_data.remaining    = in_burst;
        end else begin
            wr_en = upd_fire && best.found;
        end
    end

    pps_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        scan_beat.vld  = r_rd_vld;
        scan_beat.used = r_valid[r_rd_idx];
        scan_beat.idx  = r_rd_idx;
        scan_beat.ent  = rd_data;
    end

    pps_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_beat  (scan_beat),
        .i_now   (r_now),
        .o_best  (best)
    );

    // state, table flags, time and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pps_pkg::ST_IDLE;
            r_valid   <= '0;
            r_started <= '0;
            r_now     <= '0;
            r_last    <= pps_pkg::NO_SLOT;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_idx  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;

            // slot index travels with its read data
            if (rd_en) begin
                r_rd_idx <= r_addr;
            end

            // scan address walks the table once per tick
            if (scan_start) begin
                r_addr <= '0;
            end else if (rd_en) begin
                r_addr <= r_addr + 1'b1;
            end

            // clear and load
            if (r_state == pps_pkg::ST_IDLE && in_beat) begin
                case (s_axis_tuser)
                    pps_pkg::CMD_CLEAR: begin
                        r_valid   <= '0;
                        r_started <= '0;
                        r_now     <= pps_pkg::TIME_BITS'(in_arrival);
                        r_last    <= pps_pkg::NO_SLOT;
                    end
                    pps_pkg::CMD_LOAD: begin
                        if (load_ok) begin
                            r_valid[pps_pkg::SLOT_BITS'(in_slot)]   <= 1'b1;
                            r_started[pps_pkg::SLOT_BITS'(in_slot)] <= 1'b0;
                        end
                    end
                    default: begin
                        r_last <= r_last;
                    end
                endcase
            end

            // tick write-back
            if (upd_fire) begin
                if (best.found) begin
                    r_started[best.idx] <= 1'b1;
                    r_last <= fin ? pps_pkg::NO_SLOT : {1'b0, best.idx};
                end else begin
                    r_last <= pps_pkg::NO_SLOT;
                end
                if (r_now != '1) begin
                    r_now <= r_now + 1'b1;
                end
            end

            if (upd_fire) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // pad, all_done, tick_time, finished, first_run, switched, idle, run_slot
    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_out_data <= {7'd0, done, pps_pkg::TICK_W'(r_now), fin, first, sw,
                           !best.found, best.found ? 4'(best.idx) : 4'd0};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the preemptive priority scheduler: drives clear,
// load and tick beats, predicts each tick result from a local copy of the
// slot table and compares every result beat field by field
// ----------------------------------------------------------------------------
module testbench;

    // no name in the package for the spare command code
    localparam logic [pps_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    // settle time after the last result, scaled with SLOT_COUNT
    localparam int SETTLE_CYCLES = 2 * (pps_pkg::SLOT_COUNT + 3) + 10;

    // item counts of the random phases
    localparam int BEATS_WITH_IDLING = 1100;
    localparam int BEATS_TOTAL       = 1450;

    // one result beat, laid out as on m_axis_tdata (msb first)
    typedef struct packed {
        logic [6:0]                 pad;
        logic                       all_done;
        logic [pps_pkg::TICK_W-1:0] tick_time;
        logic                       finished;
        logic                       first_run;
        logic                       switched;
        logic                       idle;
        logic [pps_pkg::SLOT_W-1:0] run_slot;
    } t_tick_report;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [pps_pkg::CMD_W-1:0]       s_axis_tuser  = '0;   // cmd
    logic [pps_pkg::IN_DATA_W-1:0]   s_axis_tdata  = '0;   // slot, arrival_time,
                                                           // task_priority, burst_length,
                                                           // zero pad
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [pps_pkg::OUT_DATA_W-1:0]  m_axis_tdata;         // run_slot, idle, switched,
                                                           // first_run, finished,
                                                           // tick_time, all_done, zero pad

    // shadow copy of the slot table
    logic                           tbl_valid   [pps_pkg::SLOT_COUNT];
    logic [pps_pkg::ARR_W-1:0]      tbl_arrival [pps_pkg::SLOT_COUNT];
    logic [pps_pkg::PRI_W-1:0]      tbl_prio    [pps_pkg::SLOT_COUNT];
    logic [pps_pkg::BURST_W-1:0]    tbl_left    [pps_pkg::SLOT_COUNT];
    logic                           tbl_started [pps_pkg::SLOT_COUNT];
    logic [pps_pkg::TIME_BITS-1:0]  sched_now;
    logic [pps_pkg::SLOT_BITS:0]    last_run;

    t_tick_report tick_results[$];   // predicted tick results, oldest first

    int  beats_sent     = 0;
    int  results_seen   = 0;
    int  mismatch_count = 0;
    bit  idling_on      = 1'b0;      // random gaps on both sides
    int  stall_left     = 0;

    preemptive_priority_scheduler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor: applies one accepted beat to the shadow table and queues the
    // result of a tick
    // ------------------------------------------------------------------------
    function automatic void advance_schedule(logic [pps_pkg::CMD_W-1:0] cmd,
                                             logic [pps_pkg::SLOT_W-1:0] slot,
                                             logic [pps_pkg::ARR_W-1:0] arr,
                                             logic [pps_pkg::PRI_W-1:0] pri,
                                             logic [pps_pkg::BURST_W-1:0] burst);
        t_tick_report rep;
        logic [pps_pkg::SLOT_BITS:0] best;
        logic [pps_pkg::SLOT_BITS-1:0] bi;
        int i;
        rep  = '0;
        best = pps_pkg::NO_SLOT;
        case (cmd)
            pps_pkg::CMD_CLEAR: begin
                for (i = 0; i < pps_pkg::SLOT_COUNT; i++) begin
                    tbl_valid[i]   = 1'b0;
                    tbl_started[i] = 1'b0;
                end
                last_run  = pps_pkg::NO_SLOT;
                sched_now = arr;
            end
            pps_pkg::CMD_LOAD: begin
                tbl_valid[slot]   = 1'b1;
                tbl_arrival[slot] = arr;
                tbl_prio[slot]    = pri;
                tbl_left[slot]    = burst;
                tbl_started[slot] = 1'b0;
            end
            pps_pkg::CMD_TICK: begin
                // lowest priority number, then earliest arrival, then lowest index
                for (i = 0; i < pps_pkg::SLOT_COUNT; i++) begin
                    bi = best[pps_pkg::SLOT_BITS-1:0];
                    if (tbl_valid[i] && tbl_left[i] != 0 && tbl_arrival[i] <= sched_now) begin
                        if (best == pps_pkg::NO_SLOT || tbl_prio[i] < tbl_prio[bi] ||
                            (tbl_prio[i] == tbl_prio[bi] &&
                             tbl_arrival[i] < tbl_arrival[bi]))
                            best = (pps_pkg::SLOT_BITS + 1)'(i);
                    end
                end
                bi = best[pps_pkg::SLOT_BITS-1:0];
                rep.tick_time = sched_now;
                if (best == pps_pkg::NO_SLOT) begin
                    rep.idle = 1'b1;
                    last_run = pps_pkg::NO_SLOT;
                end else begin
                    rep.run_slot  = best[pps_pkg::SLOT_W-1:0];
                    rep.switched  = (best != last_run);
                    rep.first_run = !tbl_started[bi];
                    tbl_started[bi] = 1'b1;
                    tbl_left[bi]    = tbl_left[bi] - 1'b1;
                    if (tbl_left[bi] == 0) begin
                        // a finished slot clears the last-run marker
                        rep.finished = 1'b1;
                        last_run     = pps_pkg::NO_SLOT;
                    end else begin
                        last_run = best;
                    end
                end
                // time saturates at its maximum
                if (sched_now != '1)
                    sched_now = sched_now + 1'b1;
                rep.all_done = 1'b1;
                for (i = 0; i < pps_pkg::SLOT_COUNT; i++)
                    if (tbl_valid[i] && tbl_left[i] != 0)
                        rep.all_done = 1'b0;
                tick_results.insert(tick_results.size(), rep);
            end
            default: ;  // spare code does nothing
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // send one beat on s_axis; valid stays high after the handshake so that a
    // following beat can go out back to back, and is lowered by the next gap
    // ------------------------------------------------------------------------
    task automatic send_beat(logic [pps_pkg::CMD_W-1:0] cmd,
                             logic [pps_pkg::SLOT_W-1:0] slot,
                             logic [pps_pkg::ARR_W-1:0] arr,
                             logic [pps_pkg::PRI_W-1:0] pri,
                             logic [pps_pkg::BURST_W-1:0] burst);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, burst, pri, arr, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        advance_schedule(cmd, slot, arr, pri, burst);
        beats_sent++;
    endtask

    // load a random slot that arrives soon, with priorities that often tie
    task automatic send_random_load();
        logic [pps_pkg::ARR_W-1:0]   arr;
        logic [pps_pkg::PRI_W-1:0]   pri;
        logic [pps_pkg::BURST_W-1:0] burst;
        if ($urandom_range(0, 15) == 0)
            arr = pps_pkg::ARR_W'($urandom());
        else
            arr = sched_now + pps_pkg::ARR_W'($urandom_range(0, 12));
        if ($urandom_range(0, 2) == 0)
            pri = pps_pkg::PRI_W'($urandom());
        else
            pri = pps_pkg::PRI_W'($urandom_range(0, 3));
        case ($urandom_range(0, 11))
            0:       burst = '0;
            1:       burst = pps_pkg::BURST_W'($urandom());
            default: burst = pps_pkg::BURST_W'($urandom_range(1, 6));
        endcase
        send_beat(pps_pkg::CMD_LOAD, pps_pkg::SLOT_W'($urandom()), arr, pri, burst);
    endtask

    // one clear-load-run sequence with random content and some noise mixed in
    task automatic random_scenario();
        logic [pps_pkg::ARR_W-1:0] start;
        int n_loads;
        int n_ticks;
        int k;
        case ($urandom_range(0, 7))
            0:       start = pps_pkg::ARR_W'(16'hFFFF - $urandom_range(0, 20));
            1:       start = pps_pkg::ARR_W'($urandom());
            default: start = pps_pkg::ARR_W'($urandom_range(0, 300));
        endcase
        send_beat(pps_pkg::CMD_CLEAR, pps_pkg::SLOT_W'($urandom()), start,
                  pps_pkg::PRI_W'($urandom()), pps_pkg::BURST_W'($urandom()));
        n_loads = $urandom_range(1, pps_pkg::SLOT_COUNT);
        repeat (n_loads) send_random_load();
        n_ticks = $urandom_range(4, 40);
        for (k = 0; k < n_ticks; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_random_load();
            else if ($urandom_range(0, 29) == 0)
                // noise: any command with any fields
                send_beat(pps_pkg::CMD_W'($urandom()), pps_pkg::SLOT_W'($urandom()),
                          pps_pkg::ARR_W'($urandom()), pps_pkg::PRI_W'($urandom()),
                          pps_pkg::BURST_W'($urandom()));
            else
                send_beat(pps_pkg::CMD_TICK, pps_pkg::SLOT_W'($urandom()),
                          pps_pkg::ARR_W'($urandom()), pps_pkg::PRI_W'($urandom()),
                          pps_pkg::BURST_W'($urandom()));
        end
    endtask

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------

    // extremes, tie-breaks, preemption, saturation, zero burst, reload, spare code
    task automatic test_directed();
        send_beat(pps_pkg::CMD_TICK,  4'd0,  16'd0,    8'd0,   16'd0);     // idle after reset
        send_beat(pps_pkg::CMD_CLEAR, 4'd0,  16'hFFFD, 8'd0,   16'd0);
        send_beat(pps_pkg::CMD_LOAD,  4'd15, 16'hFFFF, 8'd0,   16'd2);     // arrives at max
        send_beat(pps_pkg::CMD_LOAD,  4'd0,  16'd0,    8'd255, 16'hFFFF);  // longest burst
        send_beat(pps_pkg::CMD_LOAD,  4'd5,  16'd0,    8'd0,   16'd0);     // zero burst
        send_beat(pps_pkg::CMD_TICK,  4'd0,  16'd0,    8'd0,   16'd0);     // slot 0 starts
        send_beat(pps_pkg::CMD_TICK,  4'd0,  16'd0,    8'd0,   16'd0);     // slot 0 again
        send_beat(pps_pkg::CMD_TICK,  4'd0,  16'd0,    8'd0,   16'd0);     // slot 15 preempts
        send_beat(pps_pkg::CMD_TICK,  4'd0,  16'd0,    8'd0,   16'd0);     // 15 finishes
        send_beat(pps_pkg::CMD_TICK,  4'd0,  16'd0,    8'd0,   16'd0);     // slot 0 resumes
        send_beat(CMD_SPARE,          4'hF,  16'hFFFF, 8'hFF,  16'hFFFF);  // changes nothing
        send_beat(pps_pkg::CMD_TICK,  4'hF,  16'hFFFF, 8'hFF,  16'hFFFF);
        send_beat(pps_pkg::CMD_CLEAR, 4'd0,  16'd100,  8'd0,   16'd0);
        send_beat(pps_pkg::CMD_LOAD,  4'd7,  16'd50,   8'd10,  16'd1);
        send_beat(pps_pkg::CMD_LOAD,  4'd3,  16'd50,   8'd10,  16'd1);
        send_beat(pps_pkg::CMD_LOAD,  4'd9,  16'd40,   8'd10,  16'd1);     // earlier arrival
        send_beat(pps_pkg::CMD_LOAD,  4'd2,  16'd200,  8'd0,   16'd3);     // not yet arrived
        send_beat(pps_pkg::CMD_TICK,  4'd0,  16'd0,    8'd0,   16'd0);     // slot 9
        send_beat(pps_pkg::CMD_TICK,  4'd0,  16'd0,    8'd0,   16'd0);     // slot 3
        send_beat(pps_pkg::CMD_TICK,  4'd0,  16'd0,    8'd0,   16'd0);     // slot 7
        send_beat(pps_pkg::CMD_TICK,  4'd0,  16'd0,    8'd0,   16'd0);     // idle, work pending
        send_beat(pps_pkg::CMD_LOAD,  4'd1,  16'd0,    8'd1,   16'd2);
        send_beat(pps_pkg::CMD_TICK,  4'd0,  16'd0,    8'd0,   16'd0);
        send_beat(pps_pkg::CMD_LOAD,  4'd1,  16'd0,    8'd1,   16'd1);     // reload restarts
        send_beat(pps_pkg::CMD_TICK,  4'd0,  16'd0,    8'd0,   16'd0);
    endtask

    // random sequences with gaps and stalls on both sides
    task automatic test_random_with_idling();
        idling_on = 1'b1;
        while (beats_sent < BEATS_WITH_IDLING)
            random_scenario();
    endtask

    // random sequences back to back, sink always ready
    task automatic test_random_back_to_back();
        idling_on = 1'b0;
        while (beats_sent < BEATS_TOTAL)
            random_scenario();
    endtask

    // ------------------------------------------------------------------------
    // sink side: random stall bursts while idling is on
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(1, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
                         name, results_seen, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // result checker: every accepted m_axis beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_tick_report want_rep;
        t_tick_report got_rep;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_rep = m_axis_tdata;
            if (tick_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result beat 0x%08h with no tick pending", m_axis_tdata);
            end else begin
                want_rep = tick_results.pop_front();
                check_field("run_slot",  want_rep.run_slot,  got_rep.run_slot);
                check_field("idle",      want_rep.idle,      got_rep.idle);
                check_field("switched",  want_rep.switched,  got_rep.switched);
                check_field("first_run", want_rep.first_run, got_rep.first_run);
                check_field("finished",  want_rep.finished,  got_rep.finished);
                check_field("tick_time", want_rep.tick_time, got_rep.tick_time);
                check_field("all_done",  want_rep.all_done,  got_rep.all_done);
                check_field("pad",       want_rep.pad,       got_rep.pad);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int i;
        for (i = 0; i < pps_pkg::SLOT_COUNT; i++) begin
            tbl_valid[i]   = 1'b0;
            tbl_started[i] = 1'b0;
            tbl_arrival[i] = '0;
            tbl_prio[i]    = '0;
            tbl_left[i]    = '0;
        end
        sched_now = '0;
        last_run  = pps_pkg::NO_SLOT;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_with_idling();
        test_random_back_to_back();

        // drain: all results in, then let the block settle
        s_axis_tvalid <= 1'b0;
        while (tick_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && tick_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, far above the slowest correct run
    initial begin
        #1ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pps_pkg.sv
hw/rtl/pps_slot_mem.sv
hw/rtl/pps_scan.sv
hw/rtl/preemptive_priority_scheduler.sv
sim/testbench.sv
